// ===== rtl/fmst_pkg.sv =====
package fmst_pkg;

   localparam int unsigned MODE_WIDTH = 2;
   localparam int unsigned PORT_WIDTH = 2;
   localparam int unsigned DATA_WIDTH = 8;
   localparam int unsigned ADDR_WIDTH = 9;
   localparam int unsigned CNT1_WIDTH = 11;
   localparam int unsigned CNT2_WIDTH = 13;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_TICK  = 2'd2,
      MODE_NONE  = 2'd3
   } item_mode_type;

   // Register addresses decoded by the timer block.
   localparam logic [ADDR_WIDTH-1:0] ADDR_TIMER_ONE = 9'h002;
   localparam logic [ADDR_WIDTH-1:0] ADDR_TIMER_TWO = 9'h003;
   localparam logic [ADDR_WIDTH-1:0] ADDR_TIMER_CTL = 9'h004;

   // Bit positions within the timer control byte.
   localparam int unsigned CTL_START_ONE = 0;
   localparam int unsigned CTL_START_TWO = 1;
   localparam int unsigned CTL_MASK_TWO  = 5;
   localparam int unsigned CTL_MASK_ONE  = 6;
   localparam int unsigned CTL_CLEAR     = 7;

   localparam logic [ADDR_WIDTH-1:0] PRESET_BASE = 9'd256;

endpackage

// ===== rtl/fmst_req_if.sv =====
interface fmst_req_if;
   import fmst_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [MODE_WIDTH-1:0] mode;
   logic [PORT_WIDTH-1:0] port_address;
   logic [DATA_WIDTH-1:0] write_data;

   modport source (output valid, output mode, output port_address, output write_data,
                   input ready);
   modport sink   (input valid, input mode, input port_address, input write_data,
                   output ready);
endinterface

// ===== rtl/fmst_rsp_if.sv =====
interface fmst_rsp_if;
   import fmst_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] read_data;
   logic                  irq_flag;

   modport source (output valid, output read_data, output irq_flag, input ready);
   modport sink   (input valid, input read_data, input irq_flag, output ready);
endinterface

// ===== rtl/fm_synth_timer_status_regs_core.sv =====
// Channel   Direction  Words carried
// req_bus   in         mode, port_address, write_data
// rsp_bus   out        read_data, irq_flag
// csr_*     in         opl3_mode (write only)
//
// For each accepted request word the register file and both timers update at the
// accepting edge, and the response word is loaded into the output register at that edge.
// A new request is taken every cycle while the output register is empty or being drained.
// Reset clears all timer state, the address latch and the mode register; timers stop.
// When rsp_bus stalls, one response waits in the output register and req_bus is held off.
module fm_synth_timer_status_regs_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   fmst_req_if.sink   req_bus,
   fmst_rsp_if.source rsp_bus
);
   import fmst_pkg::*;

   logic                  opl3_mode_ff;
   logic [ADDR_WIDTH-1:0] addr_ff,       addr_in;
   logic [ADDR_WIDTH-1:0] preset_one_ff, preset_one_in;
   logic [ADDR_WIDTH-1:0] preset_two_ff, preset_two_in;
   logic                  ctl_one_ff,    ctl_one_in;
   logic                  ctl_two_ff,    ctl_two_in;
   logic                  flag_one_ff,   flag_one_in;
   logic                  flag_two_ff,   flag_two_in;
   logic                  mask_one_ff,   mask_one_in;
   logic                  mask_two_ff,   mask_two_in;
   logic [CNT1_WIDTH-1:0] count_one_ff,  count_one_in;
   logic [CNT2_WIDTH-1:0] count_two_ff,  count_two_in;
   logic                  run_one_ff,    run_one_in;
   logic                  run_two_ff,    run_two_in;

   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff,   rsp_data_in;
   logic                  rsp_irq_ff,    rsp_irq_in;

   logic                  req_fire;
   logic                  irq_now;
   logic [DATA_WIDTH-1:0] wdata;
   item_mode_type         mode;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign wdata         = req_bus.write_data;
   assign mode          = item_mode_type'(req_bus.mode);

   // The "any flag" status bit is never stored: it always equals the unmasked flags.
   assign irq_now = (flag_one_ff && mask_one_ff) || (flag_two_ff && mask_two_ff);

   always_comb begin
      addr_in       = addr_ff;
      preset_one_in = preset_one_ff;
      preset_two_in = preset_two_ff;
      ctl_one_in    = ctl_one_ff;
      ctl_two_in    = ctl_two_ff;
      flag_one_in   = flag_one_ff;
      flag_two_in   = flag_two_ff;
      mask_one_in   = mask_one_ff;
      mask_two_in   = mask_two_ff;
      count_one_in  = count_one_ff;
      count_two_in  = count_two_ff;
      run_one_in    = run_one_ff;
      run_two_in    = run_two_ff;
      rsp_data_in   = '0;

      if (req_fire) begin
         case (mode)
            MODE_READ: begin
               if (!req_bus.port_address[0]) begin
                  rsp_data_in = {irq_now, flag_one_ff && mask_one_ff,
                                 flag_two_ff && mask_two_ff, 2'b00,
                                 !opl3_mode_ff, !opl3_mode_ff, 1'b0};
               end else begin
                  rsp_data_in = opl3_mode_ff ? 8'h00 : 8'hff;
               end
            end
            MODE_WRITE: begin
               if (!req_bus.port_address[0]) begin
                  addr_in = {opl3_mode_ff && req_bus.port_address[1], wdata};
               end else if (addr_ff == ADDR_TIMER_ONE) begin
                  preset_one_in = PRESET_BASE - {1'b0, wdata};
               end else if (addr_ff == ADDR_TIMER_TWO) begin
                  preset_two_in = PRESET_BASE - {1'b0, wdata};
               end else if (addr_ff == ADDR_TIMER_CTL) begin
                  if (wdata[CTL_CLEAR]) begin
                     flag_one_in = 1'b0;
                     flag_two_in = 1'b0;
                  end else begin
                     // Only a change of a start bit loads or stops its timer.
                     if (wdata[CTL_START_ONE] != ctl_one_ff) begin
                        if (wdata[CTL_START_ONE]) begin
                           count_one_in = {preset_one_ff, 2'b00};
                           run_one_in   = preset_one_ff != '0;
                        end else begin
                           count_one_in = '0;
                           run_one_in   = 1'b0;
                        end
                     end
                     if (wdata[CTL_START_TWO] != ctl_two_ff) begin
                        if (wdata[CTL_START_TWO]) begin
                           count_two_in = {preset_two_ff, 4'b0000};
                           run_two_in   = preset_two_ff != '0;
                        end else begin
                           count_two_in = '0;
                           run_two_in   = 1'b0;
                        end
                     end
                     mask_one_in = !wdata[CTL_MASK_ONE];
                     mask_two_in = !wdata[CTL_MASK_TWO];
                     ctl_one_in  = wdata[CTL_START_ONE];
                     ctl_two_in  = wdata[CTL_START_TWO];
                  end
               end
            end
            MODE_TICK: begin
               if (run_one_ff) begin
                  if (count_one_ff <= CNT1_WIDTH'(1)) begin
                     flag_one_in  = 1'b1;
                     count_one_in = {preset_one_ff, 2'b00};
                     run_one_in   = preset_one_ff != '0;
                  end else begin
                     count_one_in = count_one_ff - CNT1_WIDTH'(1);
                  end
               end
               if (run_two_ff) begin
                  if (count_two_ff <= CNT2_WIDTH'(1)) begin
                     flag_two_in  = 1'b1;
                     count_two_in = {preset_two_ff, 4'b0000};
                     run_two_in   = preset_two_ff != '0;
                  end else begin
                     count_two_in = count_two_ff - CNT2_WIDTH'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      rsp_irq_in   = (flag_one_in && mask_one_in) || (flag_two_in && mask_two_in);
      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opl3_mode_ff  <= 1'b0;
         addr_ff       <= '0;
         preset_one_ff <= '0;
         preset_two_ff <= '0;
         ctl_one_ff    <= 1'b0;
         ctl_two_ff    <= 1'b0;
         flag_one_ff   <= 1'b0;
         flag_two_ff   <= 1'b0;
         mask_one_ff   <= 1'b0;
         mask_two_ff   <= 1'b0;
         count_one_ff  <= '0;
         count_two_ff  <= '0;
         run_one_ff    <= 1'b0;
         run_two_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            opl3_mode_ff <= csr_write_data;
         end
         addr_ff       <= addr_in;
         preset_one_ff <= preset_one_in;
         preset_two_ff <= preset_two_in;
         ctl_one_ff    <= ctl_one_in;
         ctl_two_ff    <= ctl_two_in;
         flag_one_ff   <= flag_one_in;
         flag_two_ff   <= flag_two_in;
         mask_one_ff   <= mask_one_in;
         mask_two_ff   <= mask_two_in;
         count_one_ff  <= count_one_in;
         count_two_ff  <= count_two_in;
         run_one_ff    <= run_one_in;
         run_two_ff    <= run_two_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq_ff  <= rsp_irq_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;
   assign rsp_bus.irq_flag  = rsp_irq_ff;

`ifndef SYNTHESIS
   a_stopped_one_empty: assert property (@(posedge clock) disable iff (reset)
      !run_one_ff |-> count_one_ff == '0)
      else $error("timer one stopped with a nonzero count");

   a_stopped_two_empty: assert property (@(posedge clock) disable iff (reset)
      !run_two_ff |-> count_two_ff == '0)
      else $error("timer two stopped with a nonzero count");

   a_preset_nonzero: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.mode == MODE_WRITE && req_bus.port_address[0]
         && addr_ff == ADDR_TIMER_ONE |=> preset_one_ff != '0)
      else $error("timer one preset is zero after a write");

   a_opl2_status_bits: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.mode == MODE_READ && !req_bus.port_address[0] && !opl3_mode_ff
         |=> rsp_valid_ff && rsp_data_ff[2:1] == 2'b11)
      else $error("status read in OPL2 mode lost its fixed bits");
`endif

endmodule

// ===== tb/fm_synth_timer_status_regs_core_tb.sv =====
`timescale 1ns / 1ps

module fm_synth_timer_status_regs_core_tb;
   import fmst_pkg::*;

   localparam logic [7:0] FLAG_T1         = 8'h40;
   localparam logic [7:0] FLAG_T2         = 8'h20;
   localparam logic [7:0] FLAG_ANY        = 8'h80;
   localparam logic [7:0] OPL2_STATUS_PAD = 8'h06;
   localparam logic [7:0] OPL2_IDLE_READ  = 8'hff;
   localparam logic [7:0] OPL3_IDLE_READ  = 8'h00;
   localparam int unsigned PHASES         = 6;
   localparam int unsigned PHASE_WORDS    = 235;
   localparam int unsigned MAX_REPORTS    = 10;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  irq_flag;
   } rsp_word_t;

   typedef struct packed {
      item_mode_type         mode;
      logic [PORT_WIDTH-1:0] port;
      logic [DATA_WIDTH-1:0] data;
      logic                  opl3;
      logic                  pinned;
      rsp_word_t             pinned_word;
   } directed_row_t;

   // The opl3 column is the mode setting the row runs under; pinned rows carry a
   // response that is plain from the register description alone.
   localparam directed_row_t DIRECTED [26] = '{
      '{MODE_READ,  2'd0, 8'h00, 1'b0, 1'b1, '{8'h06, 1'b0}},
      '{MODE_READ,  2'd1, 8'h00, 1'b0, 1'b1, '{8'hff, 1'b0}},
      '{MODE_READ,  2'd2, 8'hff, 1'b0, 1'b1, '{8'h06, 1'b0}},
      '{MODE_TICK,  2'd3, 8'hff, 1'b0, 1'b1, '{8'h00, 1'b0}},
      '{MODE_NONE,  2'd3, 8'hff, 1'b0, 1'b1, '{8'h00, 1'b0}},
      '{MODE_WRITE, 2'd0, 8'h04, 1'b0, 1'b0, '0},
      '{MODE_WRITE, 2'd1, 8'h01, 1'b0, 1'b0, '0},
      '{MODE_WRITE, 2'd0, 8'h02, 1'b0, 1'b0, '0},
      '{MODE_WRITE, 2'd1, 8'hff, 1'b0, 1'b0, '0},
      '{MODE_WRITE, 2'd0, 8'h03, 1'b0, 1'b0, '0},
      '{MODE_WRITE, 2'd1, 8'h00, 1'b0, 1'b0, '0},
      '{MODE_WRITE, 2'd0, 8'h04, 1'b0, 1'b0, '0},
      '{MODE_WRITE, 2'd1, 8'h00, 1'b0, 1'b0, '0},
      '{MODE_WRITE, 2'd1, 8'h03, 1'b0, 1'b0, '0},
      '{MODE_TICK,  2'd0, 8'h00, 1'b0, 1'b0, '0},
      '{MODE_TICK,  2'd1, 8'h00, 1'b0, 1'b0, '0},
      '{MODE_TICK,  2'd2, 8'h00, 1'b0, 1'b0, '0},
      '{MODE_TICK,  2'd3, 8'h00, 1'b0, 1'b0, '0},
      '{MODE_READ,  2'd2, 8'h00, 1'b0, 1'b0, '0},
      '{MODE_WRITE, 2'd1, 8'h80, 1'b0, 1'b0, '0},
      '{MODE_READ,  2'd0, 8'h00, 1'b0, 1'b0, '0},
      '{MODE_READ,  2'd1, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0}},
      '{MODE_WRITE, 2'd2, 8'h04, 1'b1, 1'b0, '0},
      '{MODE_WRITE, 2'd3, 8'h80, 1'b1, 1'b0, '0},
      '{MODE_WRITE, 2'd0, 8'h04, 1'b1, 1'b0, '0},
      '{MODE_WRITE, 2'd1, 8'h42, 1'b1, 1'b0, '0}
   };

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   fmst_req_if req_bus ();
   fmst_rsp_if rsp_bus ();

   fm_synth_timer_status_regs_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   // Shadow copy of the timer and status registers.
   logic                  opl3_q;
   logic [ADDR_WIDTH-1:0] latch_q;
   logic [ADDR_WIDTH-1:0] preset_one_q;
   logic [ADDR_WIDTH-1:0] preset_two_q;
   logic [7:0]            control_q;
   logic [7:0]            status_q;
   logic [7:0]            mask_q;
   logic [CNT1_WIDTH-1:0] count_one_q;
   logic [CNT2_WIDTH-1:0] count_two_q;
   logic                  run_one_q;
   logic                  run_two_q;

   rsp_word_t   pending_rsp [$];
   int unsigned failures;
   int unsigned reads_sent;
   int unsigned writes_sent;
   int unsigned ticks_sent;
   int unsigned other_sent;
   int unsigned mode_writes;
   int unsigned expiries_one;
   int unsigned expiries_two;
   bit          steady_sender;
   bit          steady_receiver;

   function automatic void load_one();
      count_one_q = {preset_one_q, 2'b00};
      run_one_q   = preset_one_q != '0;
   endfunction

   function automatic void load_two();
      count_two_q = {preset_two_q, 4'b0000};
      run_two_q   = preset_two_q != '0;
   endfunction

   function automatic rsp_word_t timer_regs_step(item_mode_type m, logic [PORT_WIDTH-1:0] port,
                                                 logic [DATA_WIDTH-1:0] data);
      rsp_word_t             w;
      logic [ADDR_WIDTH-1:0] a;
      logic [7:0]            diff;
      w.read_data = '0;
      case (m)
         MODE_READ: begin
            if (!port[0])
               w.read_data = (status_q & mask_q) | (opl3_q ? 8'h00 : OPL2_STATUS_PAD);
            else
               w.read_data = opl3_q ? OPL3_IDLE_READ : OPL2_IDLE_READ;
         end
         MODE_WRITE: begin
            if (!port[0]) begin
               a = {1'b0, data};
               if (opl3_q && port[1])
                  a[8] = 1'b1;
               latch_q = a;
            end else if (latch_q == ADDR_TIMER_ONE) begin
               preset_one_q = PRESET_BASE - {1'b0, data};
            end else if (latch_q == ADDR_TIMER_TWO) begin
               preset_two_q = PRESET_BASE - {1'b0, data};
            end else if (latch_q == ADDR_TIMER_CTL) begin
               if (data[CTL_CLEAR]) begin
                  status_q = status_q & ~(FLAG_T1 | FLAG_T2);
               end else begin
                  diff = data ^ control_q;
                  if (diff[CTL_START_ONE]) begin
                     if (data[CTL_START_ONE]) begin
                        load_one();
                     end else begin
                        count_one_q = '0;
                        run_one_q   = 1'b0;
                     end
                  end
                  if (diff[CTL_START_TWO]) begin
                     if (data[CTL_START_TWO]) begin
                        load_two();
                     end else begin
                        count_two_q = '0;
                        run_two_q   = 1'b0;
                     end
                  end
                  mask_q    = (~data & (FLAG_T1 | FLAG_T2)) | FLAG_ANY;
                  control_q = data;
               end
            end
         end
         MODE_TICK: begin
            if (run_one_q) begin
               if (count_one_q <= 1) begin
                  status_q = status_q | FLAG_T1;
                  expiries_one++;
                  load_one();
               end else begin
                  count_one_q--;
               end
            end
            if (run_two_q) begin
               if (count_two_q <= 1) begin
                  status_q = status_q | FLAG_T2;
                  expiries_two++;
                  load_two();
               end else begin
                  count_two_q--;
               end
            end
         end
         MODE_NONE: ;
      endcase
      // The summary bit always follows the flags and the mask, so refreshing it on every
      // word is the same as refreshing it only where they change.
      if ((status_q & mask_q & (FLAG_T1 | FLAG_T2)) != '0)
         status_q = status_q | FLAG_ANY;
      else
         status_q = status_q & ~FLAG_ANY;
      w.irq_flag = status_q[7];
      return w;
   endfunction

   function automatic int unsigned idle_draw(bit steady);
      return steady ? 0 : $urandom_range(0, 15);
   endfunction

   // Present one request word and hold it until the block takes it.
   task automatic send_word(item_mode_type m, logic [PORT_WIDTH-1:0] port,
                            logic [DATA_WIDTH-1:0] data, bit pinned = 1'b0,
                            rsp_word_t pinned_word = '0);
      int unsigned gap;
      rsp_word_t   predicted;
      gap = idle_draw(steady_sender);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= m;
      req_bus.port_address <= port;
      req_bus.write_data   <= data;
      do @(posedge clock); while (!req_bus.ready);
      predicted = timer_regs_step(m, port, data);
      pending_rsp.push_back(pinned ? pinned_word : predicted);
      case (m)
         MODE_READ:  reads_sent++;
         MODE_WRITE: writes_sent++;
         MODE_TICK:  ticks_sent++;
         MODE_NONE:  other_sent++;
      endcase
   endtask

   // Stop sending and let every outstanding response word drain.
   task automatic drain_responses();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_opl3_mode(logic value);
      drain_responses();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      opl3_q = value;
      mode_writes++;
   endtask

   task automatic report_failure(string what, rsp_word_t want, rsp_word_t got);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("%0t %s: read_data exp %h got %h, irq_flag exp %b got %b", $time, what,
                  want.read_data, got.read_data, want.irq_flag, got.irq_flag);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin : check_rsp
      rsp_word_t want;
      rsp_word_t got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.read_data = rsp_bus.read_data;
         got.irq_flag  = rsp_bus.irq_flag;
         if (pending_rsp.size() == 0) begin
            report_failure("unexpected word", '0, got);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want)
               report_failure("mismatch", want, got);
         end
      end
   end

   // Response side: a random stall before each word, with calm stretches.
   initial begin : rsp_side
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 19) == 0)
            steady_receiver = !steady_receiver;
         stall = idle_draw(steady_receiver);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin : stimulus
      int unsigned phase_words;
      int unsigned pick;
      int unsigned burst;
      logic [7:0]  byte_val;

      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.mode         = MODE_READ;
      req_bus.port_address = '0;
      req_bus.write_data   = '0;
      failures             = 0;
      reads_sent           = 0;
      writes_sent          = 0;
      ticks_sent           = 0;
      other_sent           = 0;
      mode_writes          = 0;
      expiries_one         = 0;
      expiries_two         = 0;
      steady_sender        = 1'b0;
      steady_receiver      = 1'b0;
      opl3_q               = 1'b0;
      latch_q              = '0;
      preset_one_q         = '0;
      preset_two_q         = '0;
      control_q            = '0;
      status_q             = '0;
      mask_q               = '0;
      count_one_q          = '0;
      count_two_q          = '0;
      run_one_q            = 1'b0;
      run_two_q            = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_opl3_mode(1'b0);
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].opl3 != opl3_q)
            set_opl3_mode(DIRECTED[i].opl3);
         send_word(DIRECTED[i].mode, DIRECTED[i].port, DIRECTED[i].data,
                   DIRECTED[i].pinned, DIRECTED[i].pinned_word);
      end

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         set_opl3_mode(phase[0] ? 1'b1 : 1'b0);
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            if ($urandom_range(0, 4) == 0)
               steady_sender = !steady_sender;
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               // Preset load: address 2 or 3, then a data word that mostly gives a short period.
               send_word(MODE_WRITE, {1'($urandom_range(0, 3) == 0), 1'b0},
                         8'($urandom_range(2, 3)));
               byte_val = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'he0, 8'hff))
                                                      : 8'($urandom);
               send_word(MODE_WRITE, {1'($urandom_range(0, 3) == 0), 1'b1}, byte_val);
               phase_words += 2;
            end else if (pick < 45) begin
               send_word(MODE_WRITE, {1'($urandom_range(0, 3) == 0), 1'b0}, 8'(ADDR_TIMER_CTL));
               byte_val = 8'($urandom);
               if ($urandom_range(0, 3) != 0)
                  byte_val[CTL_CLEAR] = 1'b0;
               send_word(MODE_WRITE, {1'($urandom_range(0, 3) == 0), 1'b1}, byte_val);
               phase_words += 2;
            end else if (pick < 75) begin
               burst = $urandom_range(1, 40);
               repeat (burst)
                  send_word(MODE_TICK, 2'($urandom), 8'($urandom));
               phase_words += burst;
            end else if (pick < 90) begin
               send_word(MODE_READ, 2'($urandom), 8'($urandom));
               phase_words++;
            end else if (pick < 98) begin
               send_word(item_mode_type'(2'($urandom)), 2'($urandom), 8'($urandom));
               phase_words++;
            end else begin
               // Hold off until the response side has caught up completely.
               drain_responses();
            end
         end
      end

      drain_responses();
      repeat (8) @(posedge clock);
      $display("Covered %0d reads, %0d writes, %0d ticks and %0d unused-mode words",
               reads_sent, writes_sent, ticks_sent, other_sent);
      $display("Mode register written %0d times; timer one expired %0d times, timer two %0d",
               mode_writes, expiries_one, expiries_two);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures", failures);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
